### design/oss_pkg.sv
// Package: shared types, constants and codes for the ordered sequence store.
package oss_pkg;
    localparam int Capacity   = 64;
    localparam int IdxW       = $clog2(Capacity);
    localparam int CntW       = $clog2(Capacity + 1);
    localparam int ValueWidth = 32;

    typedef enum logic [2:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE_AT      = 3'd2,
        OP_REMOVE_ALL    = 3'd3,
        OP_READ_AT       = 3'd4,
        OP_WRITE_AT      = 3'd5,
        OP_FIND_FIRST    = 3'd6,
        OP_UNUSED        = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  position;
        logic [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [6:0]  found_index;
        logic [6:0]  removed_count;
        logic [6:0]  element_count;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_COMPACT,
        ST_PUT,
        ST_DONE
    } t_state;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic shift_up_step;
        logic shift_down_step;
        logic compact_step;
        logic put;
        logic finish;
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        t_op  op;
        logic valid_req;
        logic scan_hit;
        logic scan_end;
        logic shift_end;
    } t_sts;
endpackage

### design/ordered_sequence_store.sv
// Top level: bounded ordered list with positional and sorted insert, erase, remove-all, read, write and search.
// A request is taken when i_start is high and o_busy is low; its single result appears
// on o_rsp with o_done high for one cycle and cannot be stalled. A request may walk
// elements by scan, shift or compaction over the element memory, which has one read
// and one write port; no new request is taken until the last one is done.
module ordered_sequence_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  oss_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output oss_pkg::t_rsp o_rsp
);
    import oss_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    oss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    oss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_done)
    );
endmodule

### design/oss_ctrl.sv
// Controller: sequences the scan, shift, compact and write phases of a request.
module oss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  oss_pkg::t_sts i_sts,
    output oss_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import oss_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!i_sts.valid_req) begin
                    n_state = ST_DONE;
                end else begin
                    case (i_sts.op)
                        OP_INSERT_SORTED: begin
                            if (i_sts.scan_hit || i_sts.scan_end) n_state = ST_SHIFT_UP;
                        end
                        OP_FIND_FIRST: begin
                            if (i_sts.scan_hit || i_sts.scan_end) n_state = ST_DONE;
                        end
                        OP_INSERT_AT:  n_state = ST_SHIFT_UP;
                        OP_ERASE_AT:   n_state = ST_SHIFT_DOWN;
                        OP_REMOVE_ALL: n_state = ST_COMPACT;
                        OP_WRITE_AT:   n_state = ST_PUT;
                        default:       n_state = ST_DONE;
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (i_sts.shift_end) n_state = ST_PUT;
            end
            ST_SHIFT_DOWN: begin
                if (i_sts.shift_end) n_state = ST_DONE;
            end
            ST_COMPACT: begin
                if (i_sts.scan_end) n_state = ST_DONE;
            end
            ST_PUT:  n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:       o_cmd.load = i_start;
            ST_SCAN:       o_cmd.scan_step = 1'b1;
            ST_SHIFT_UP:   o_cmd.shift_up_step = !i_sts.shift_end;
            ST_SHIFT_DOWN: o_cmd.shift_down_step = !i_sts.shift_end;
            ST_COMPACT:    o_cmd.compact_step = !i_sts.scan_end;
            ST_PUT:        o_cmd.put = 1'b1;
            ST_DONE:       o_cmd.finish = 1'b1;
            default:       o_cmd = '0;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("multiple commands");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_busy) else $error("finish not followed by idle");
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_busy) else $error("load without busy");
endmodule

### design/oss_dp.sv
// Datapath: element memory, count, walk pointers and result register.
module oss_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  oss_pkg::t_req i_req,
    input  oss_pkg::t_cmd i_cmd,
    output oss_pkg::t_sts o_sts,
    output oss_pkg::t_rsp o_rsp,
    output logic          o_rsp_valid
);
    import oss_pkg::*;

    logic [ValueWidth-1:0] r_mem [Capacity];

    t_req               r_req;
    logic [CntW-1:0]    r_count;
    logic [CntW-1:0]    r_ptr;       // scan / compact read index
    logic [CntW-1:0]    r_wr;        // compact write index / shift cursor
    logic [CntW-1:0]    r_target;    // insertion, write or erase position; found index for a search
    logic [6:0]         r_removed;
    logic               r_found;
    logic               r_ok;
    logic [ValueWidth-1:0] r_rd;
    logic [ValueWidth-1:0] r_rdata;
    t_rsp               r_rsp;
    logic               r_rsp_valid;

    logic [ValueWidth-1:0] w_val;
    logic [CntW-1:0]       w_pos;
    logic                  w_pos_lt;
    logic                  w_pos_le;
    logic                  w_full;
    logic [ValueWidth-1:0] w_cur;
    logic [IdxW-1:0]       w_raddr;
    t_op                   w_op;

    assign w_op     = t_op'(r_req.operation);
    assign w_val    = r_req.item_value[ValueWidth-1:0];
    assign w_pos    = CntW'(r_req.position);
    assign w_pos_lt = ({1'b0, r_req.position} < (CntW+1)'(r_count));
    assign w_pos_le = ({1'b0, r_req.position} <= (CntW+1)'(r_count));
    assign w_full   = (r_count == CntW'(Capacity));
    assign w_cur    = r_rdata;

    always_comb begin
        o_sts.op        = w_op;
        o_sts.scan_end  = (r_ptr >= r_count);
        o_sts.scan_hit  = 1'b0;
        o_sts.shift_end = 1'b0;
        case (w_op)
            OP_INSERT_SORTED: o_sts.scan_hit = !o_sts.scan_end && (w_cur > w_val);
            OP_FIND_FIRST:    o_sts.scan_hit = !o_sts.scan_end && (w_cur == w_val);
            default:          o_sts.scan_hit = 1'b0;
        endcase
        case (w_op)
            OP_ERASE_AT: o_sts.shift_end = (r_wr + CntW'(1) >= r_count);
            default:     o_sts.shift_end = (r_wr <= r_target);
        endcase
        case (w_op)
            OP_INSERT_AT:     o_sts.valid_req = !w_full && w_pos_le;
            OP_INSERT_SORTED: o_sts.valid_req = !w_full;
            OP_ERASE_AT,
            OP_READ_AT,
            OP_WRITE_AT:      o_sts.valid_req = w_pos_lt;
            OP_REMOVE_ALL,
            OP_FIND_FIRST:    o_sts.valid_req = 1'b1;
            default:          o_sts.valid_req = 1'b0;
        endcase
    end

    // Read address is registered into r_rdata, so it selects the element the next cycle uses.
    always_comb begin
        w_raddr = '0;
        if (i_cmd.load) begin
            if (t_op'(i_req.operation) == OP_READ_AT) w_raddr = i_req.position[IdxW-1:0];
        end else if (i_cmd.scan_step) begin
            case (w_op)
                OP_ERASE_AT:   w_raddr = IdxW'(w_pos + CntW'(1));
                OP_REMOVE_ALL: w_raddr = '0;
                OP_INSERT_SORTED,
                OP_FIND_FIRST: begin
                    if (o_sts.scan_hit || o_sts.scan_end) w_raddr = IdxW'(r_count - CntW'(1));
                    else w_raddr = IdxW'(r_ptr + CntW'(1));
                end
                default:       w_raddr = IdxW'(r_count - CntW'(1));
            endcase
        end else if (i_cmd.shift_up_step) begin
            w_raddr = IdxW'(r_wr - CntW'(2));
        end else if (i_cmd.shift_down_step) begin
            w_raddr = IdxW'(r_wr + CntW'(2));
        end else if (i_cmd.compact_step) begin
            w_raddr = IdxW'(r_ptr + CntW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_up_step || i_cmd.shift_down_step) begin
            r_mem[r_wr[IdxW-1:0]] <= r_rdata;
        end else if (i_cmd.compact_step && (w_cur != w_val)) begin
            r_mem[r_wr[IdxW-1:0]] <= w_cur;
        end else if (i_cmd.put) begin
            r_mem[r_target[IdxW-1:0]] <= w_val;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_ptr     <= '0;
            r_removed <= '0;
            r_found   <= 1'b0;
            r_ok      <= 1'b0;
            r_rd      <= '0;
        end
        if (i_cmd.scan_step) begin
            r_ok <= o_sts.valid_req;
            case (w_op)
                OP_ERASE_AT: begin
                    r_target <= w_pos;
                    r_wr     <= w_pos;
                end
                OP_REMOVE_ALL: begin
                    r_target <= w_pos;
                    r_ptr    <= '0;
                    r_wr     <= '0;
                end
                OP_READ_AT: begin
                    r_target <= w_pos;
                    r_wr     <= r_count;
                    r_rd     <= o_sts.valid_req ? r_rdata : '0;
                end
                OP_INSERT_SORTED,
                OP_FIND_FIRST: begin
                    r_target <= r_ptr;
                    r_wr     <= r_count;
                    r_found  <= o_sts.scan_hit;
                    if (!o_sts.scan_hit && !o_sts.scan_end) r_ptr <= r_ptr + CntW'(1);
                end
                default: begin
                    r_target <= w_pos;
                    r_wr     <= r_count;
                end
            endcase
        end
        if (i_cmd.shift_up_step) r_wr <= r_wr - CntW'(1);
        if (i_cmd.shift_down_step) r_wr <= r_wr + CntW'(1);
        if (i_cmd.compact_step) begin
            r_ptr <= r_ptr + CntW'(1);
            if (w_cur == w_val) r_removed <= r_removed + 7'd1;
            else r_wr <= r_wr + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= i_cmd.finish;
            if (i_cmd.put && (w_op == OP_INSERT_AT || w_op == OP_INSERT_SORTED)) begin
                r_count <= r_count + CntW'(1);
            end
            if (i_cmd.finish && r_ok && w_op == OP_ERASE_AT) r_count <= r_count - CntW'(1);
            if (i_cmd.finish && w_op == OP_REMOVE_ALL) r_count <= r_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp.ok            <= r_ok;
            r_rsp.read_value    <= 32'(r_rd);
            r_rsp.found_index   <= (w_op != OP_FIND_FIRST) ? 7'd0 :
                                   (r_found ? 7'(r_target) : 7'h7f);
            r_rsp.removed_count <= r_removed;
            case (w_op)
                OP_ERASE_AT:   r_rsp.element_count <= 7'(r_ok ? r_count - CntW'(1) : r_count);
                OP_REMOVE_ALL: r_rsp.element_count <= 7'(r_wr);
                default:       r_rsp.element_count <= 7'(r_count);
            endcase
        end
    end

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Capacity)) else $error("count overflow");
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && w_op != OP_WRITE_AT) |-> !w_full) else $error("insert into full list");
    a_rsp_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |=> !r_rsp_valid) else $error("result held two cycles");
endmodule
